@@ hdl/bole_pkg.sv @@
// shared types, constants and codes of the bounded ordered list engine
package bole_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CMP_W    = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    F_INS_FRONT = 3'd0,
    F_INS_REAR  = 3'd1,
    F_INS_POS   = 3'd2,
    F_DEL_FRONT = 3'd3,
    F_DEL_REAR  = 3'd4,
    F_DEL_POS   = 3'd5,
    F_SEARCH    = 3'd6,
    F_UPDATE    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             del;
    logic             upd;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      key;
    logic [31:0]      value;
  } ctl_t;

endpackage

@@ hdl/bole_cell.sv @@
// one list cell: holds an entry, shifts with its neighbors and compares against the key
module bole_cell import bole_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] index_i,
  input  ctl_t             ctl_i,
  input  logic [31:0]      left_i,
  input  logic [31:0]      right_i,
  input  logic             hit_i,
  output logic [31:0]      word_o,
  output logic             eq_o
);

  logic [31:0] word_q, word_d;
  logic        eq_q, eq_d;
  logic [CNT_W:0] index_p1;

  assign index_p1 = {1'b0, index_i} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      // open a gap at idx, everything behind it moves back by one
      if (index_i == ctl_i.idx) begin
        word_d = ctl_i.value;
      end else if (index_i > ctl_i.idx && index_i <= ctl_i.cnt) begin
        word_d = left_i;
      end
    end else if (ctl_i.del) begin
      // close the gap at idx
      if (index_i >= ctl_i.idx && index_p1 < {1'b0, ctl_i.cnt}) begin
        word_d = right_i;
      end
    end else if (ctl_i.upd && hit_i) begin
      word_d = ctl_i.value;
    end
  end

  // only cells inside the list may report a match
  assign eq_d = ctl_i.cmp ? ((word_q == ctl_i.key) && (index_i < ctl_i.cnt)) : eq_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q <= 1'b0;
    end else begin
      eq_q <= eq_d;
    end
  end

  assign word_o = word_q;
  assign eq_o   = eq_q;

endmodule

@@ hdl/bole_hit_enc.sv @@
// first-match isolation and position encoding over the cell match flags
module bole_hit_enc import bole_pkg::*; (
  input  logic [CAPACITY-1:0] eq_i,
  output logic [CAPACITY-1:0] first_o,
  output logic                hit_o,
  output logic [IDX_W-1:0]    idx_o
);

  // lowest set bit: eq & -eq
  assign first_o = eq_i & (~eq_i + {{(CAPACITY-1){1'b0}}, 1'b1});
  assign hit_o   = |eq_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_o[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

endmodule

@@ hdl/bounded_ordered_list_engine.sv @@
// top level of the bounded ordered list engine: control, cell chain and result register
//
// usage
//   - requests enter on the in channel (in_valid_i / in_ready_o) with func_i,
//     value_i, match_value_i and position_i; each request gives one result
//     word on the out channel (out_valid_o / out_ready_i): status, data, count
//   - a request passes accept, a compare cycle in which every
//     cell registers its match against the key, and an execute cycle in
//     which the cells shift or load in parallel and the result is registered
//   - a new request is accepted only after the previous one leaves the
//     execute cycle of the accept / compare / execute sequencer
//   - the result sits in an output register; a new request is accepted while
//     it waits, and the execute cycle holds until that register is free
//   - reset empties the list (count zero) and clears the output valid; the
//     entry storage itself is not cleared
//   - a receiver stall only delays the execute cycle, nothing is dropped
module bounded_ordered_list_engine import bole_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] match_value_i,
  input  logic [4:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] data_o,
  output logic [4:0]         count_o
);

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   exec_go;

  // request registers
  func_e       func_q;
  logic [31:0] value_q;
  logic [31:0] match_q;
  logic [4:0]  pos_q;

  // list length
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // result register
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [31:0] data_q, data_d;
  logic [4:0]  count_q, count_d;

  // cell chain
  ctl_t                ctl;
  logic [31:0]         words [CAPACITY];
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] first;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;

  // execute decode
  logic             do_ins, do_del, do_upd;
  logic [CNT_W-1:0] idx;
  logic             full, empty;
  logic [CMP_W-1:0] pos_ext, cnt_ext, lim_ext, new_cnt_ext;
  logic [4:0]       pos_m1;
  logic [31:0]      rd_word;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  // execute only when the result register can take the word
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_e'(func_i);
      value_q <= value_i;
      match_q <= match_value_i;
      pos_q   <= position_i;
    end
  end

  // operation decode, status and result data
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(cnt_q);
  assign lim_ext = (cnt_ext > CMP_W'(1)) ? cnt_ext : CMP_W'(1);
  assign pos_m1  = pos_q - 5'd1;
  assign rd_word = words[idx[IDX_W-1:0]];

  always_comb begin
    status_d = ST_OK;
    data_d   = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_upd   = 1'b0;
    idx      = '0;
    cnt_d    = cnt_q;
    case (func_q)
      F_INS_FRONT, F_INS_REAR: begin
        idx = (func_q == F_INS_FRONT) ? '0 : cnt_q;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      F_INS_POS: begin
        idx = CNT_W'(pos_m1);
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_q == 5'd0 || pos_ext > lim_ext) begin
          status_d = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      F_DEL_FRONT, F_DEL_REAR: begin
        idx = (func_q == F_DEL_FRONT) ? '0 : (cnt_q - CNT_W'(1));
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          data_d = rd_word;
        end
      end
      F_DEL_POS: begin
        idx = CNT_W'(pos_m1);
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_q == 5'd0 || pos_ext > cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          data_d = rd_word;
        end
      end
      F_SEARCH: begin
        if (hit) begin
          data_d = 32'(hit_idx) + 32'd1;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      F_UPDATE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!hit) begin
          status_d = ST_NOTFOUND;
        end else begin
          do_upd = 1'b1;
        end
      end
      default: status_d = ST_OK;
    endcase
    if (do_ins) cnt_d = cnt_q + CNT_W'(1);
    if (do_del) cnt_d = cnt_q - CNT_W'(1);
  end

  // count is reported modulo 32
  assign new_cnt_ext = CMP_W'(cnt_d);
  assign count_d     = new_cnt_ext[4:0];

  // command to the chain: compare in the compare cycle, move in the execute cycle
  always_comb begin
    ctl.cmp   = (state_q == S_CMP);
    ctl.ins   = exec_go && do_ins;
    ctl.del   = exec_go && do_del;
    ctl.upd   = exec_go && do_upd;
    ctl.idx   = idx;
    ctl.cnt   = cnt_q;
    ctl.key   = (func_q == F_UPDATE) ? match_q : value_q;
    ctl.value = value_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    bole_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .index_i (CNT_W'(i)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .hit_i   (first[i]),
      .word_o  (words[i]),
      .eq_o    (eq[i])
    );
  end

  bole_hit_enc u_hit_enc (
    .eq_i    (eq),
    .first_o (first),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  // result register, freed by the receiver
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (exec_go) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      status_q <= status_d;
      data_q   <= data_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign count_o     = count_q;

endmodule
